// ----- design/clfr_pkg.sv -----
// Package for the CRLF line framer: default sizes, character codes, operation
// and result codes, transfer payload structs and controller/datapath bundles.
// No dependencies.
package clfr_pkg;

  localparam int MESSAGE_LENGTH_DEF = 64;
  localparam int MESSAGE_SLOTS_DEF  = 8;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_NONE = 1'b1
  } kind_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic [6:0] message_length;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop_start;
    logic load_byte;
    logic load_empty;
  } cmd_t;

  typedef struct packed {
    logic ring_empty;
    logic last_byte;
  } status_t;

endpackage

// ----- design/clfr_ctrl.sv -----
// Controller for the CRLF line framer: sequences pops and owns the handshakes.
// Depends on clfr_pkg; drives the datapath clfr_dp through cmd_t and status_t.
module clfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  clfr_pkg::op_t     req_op,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output clfr_pkg::cmd_t    cmd,
  input  clfr_pkg::status_t status
);
  import clfr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_STREAM
  } state_t;

  state_t state;
  logic   req_fire;
  logic   rsp_free;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  always_comb begin
    cmd.push       = req_fire && (req_op == OP_BYTE);
    cmd.pop_start  = req_fire && (req_op == OP_POP) && !status.ring_empty;
    cmd.load_empty = (state == ST_EMPTY) && rsp_free;
    cmd.load_byte  = (state == ST_STREAM) && rsp_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.load_byte || cmd.load_empty) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire && (req_op == OP_POP)) begin
            state <= status.ring_empty ? ST_EMPTY : ST_STREAM;
          end
        end
        ST_EMPTY: begin
          if (cmd.load_empty) begin
            state <= ST_IDLE;
          end
        end
        ST_STREAM: begin
          if (cmd.load_byte && status.last_byte) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_byte || cmd.load_empty) |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten while a transfer is pending");

  a_stream_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STREAM && cmd.load_byte && status.last_byte) |=> req_ready)
    else $error("controller did not return to idle after the last byte");

  a_no_push_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !(cmd.push || cmd.pop_start))
    else $error("new item started while a pop is in progress");

endmodule

// ----- design/clfr_dp.sv -----
// Datapath for the CRLF line framer: byte store, closed slot length store,
// ring pointers, framing flags and the result register. Depends on clfr_pkg.
module clfr_dp #(
  parameter int MESSAGE_LENGTH = clfr_pkg::MESSAGE_LENGTH_DEF,
  parameter int MESSAGE_SLOTS  = clfr_pkg::MESSAGE_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  clfr_pkg::cmd_t    cmd,
  output clfr_pkg::status_t status,
  output clfr_pkg::rsp_t    rsp_data
);
  import clfr_pkg::*;

  localparam int SW    = $clog2(MESSAGE_SLOTS);
  localparam int PW    = $clog2(MESSAGE_LENGTH);
  localparam int LW    = $clog2(MESSAGE_LENGTH + 1);
  localparam int AW    = SW + PW;
  localparam int DEPTH = MESSAGE_SLOTS * (1 << PW);

  logic [7:0]    byte_mem [DEPTH];
  logic [LW-1:0] len_mem  [MESSAGE_SLOTS];

  logic [SW-1:0] read_slot;
  logic [SW-1:0] write_slot;
  logic          ring_full;
  logic          skip_to_crlf;
  logic          last_was_cr;
  logic [LW-1:0] fill;
  logic [PW-1:0] pos;
  logic [LW-1:0] msg_len;
  logic [7:0]    rdata;

  logic          crlf;
  logic          room;
  logic          wr_ok;
  logic          byte_we;
  logic          close;
  logic          skip_to_crlf_next;
  logic [SW-1:0] write_slot_inc;
  logic [SW-1:0] read_slot_inc;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic [LW-1:0] close_len;

  always_comb begin
    crlf           = last_was_cr && (rx_byte == CH_LF);
    room           = fill < LW'(MESSAGE_LENGTH);
    wr_ok          = cmd.push && !ring_full && !skip_to_crlf;
    byte_we        = wr_ok && room;
    close          = wr_ok && (!room || crlf);
    close_len      = room ? (fill + LW'(1)) : fill;
    write_slot_inc = (write_slot == SW'(MESSAGE_SLOTS - 1)) ? '0 : write_slot + SW'(1);
    read_slot_inc  = (read_slot == SW'(MESSAGE_SLOTS - 1)) ? '0 : read_slot + SW'(1);
    skip_to_crlf_next = skip_to_crlf;
    if (cmd.push) begin
      skip_to_crlf_next = (skip_to_crlf || (wr_ok && !room)) && !crlf;
    end
    status.ring_empty = !ring_full && (write_slot == read_slot);
    status.last_byte  = (LW'(pos) + LW'(1)) == msg_len;
    rd_en = cmd.pop_start || (cmd.load_byte && !status.last_byte);
    raddr = cmd.pop_start ? {read_slot, PW'(0)} : {read_slot, PW'(pos + PW'(1))};
  end

  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[{write_slot, fill[PW-1:0]}] <= rx_byte;
    end
    if (close) begin
      len_mem[write_slot] <= close_len;
    end
    if (rd_en) begin
      rdata <= byte_mem[raddr];
    end
    if (cmd.pop_start) begin
      msg_len <= len_mem[read_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_slot    <= '0;
      write_slot   <= '0;
      ring_full    <= 1'b0;
      skip_to_crlf <= 1'b0;
      last_was_cr  <= 1'b0;
      fill         <= '0;
    end else begin
      if (cmd.push) begin
        skip_to_crlf <= skip_to_crlf_next;
        last_was_cr  <= (rx_byte == CH_CR);
      end
      if (close) begin
        write_slot <= write_slot_inc;
        fill       <= '0;
        if (write_slot_inc == read_slot) begin
          ring_full <= 1'b1;
        end
      end else if (byte_we) begin
        fill <= fill + LW'(1);
      end
      if (cmd.load_byte && status.last_byte) begin
        read_slot <= read_slot_inc;
        ring_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_start) begin
      pos <= '0;
    end else if (cmd.load_byte && !status.last_byte) begin
      pos <= pos + PW'(1);
    end
    if (cmd.load_byte) begin
      rsp_data.kind           <= KIND_BYTE;
      rsp_data.data_byte      <= rdata;
      rsp_data.byte_index     <= 6'(pos);
      rsp_data.message_length <= 7'(msg_len);
      rsp_data.last           <= status.last_byte;
    end else if (cmd.load_empty) begin
      rsp_data.kind           <= KIND_NONE;
      rsp_data.data_byte      <= '0;
      rsp_data.byte_index     <= '0;
      rsp_data.message_length <= '0;
      rsp_data.last           <= 1'b1;
    end
  end

  a_full_pointers: assert property (@(posedge clk) disable iff (rst)
    ring_full |-> (write_slot == read_slot))
    else $error("ring marked full with the pointers apart");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LW'(MESSAGE_LENGTH))
    else $error("slot fill count beyond the slot size");

  a_full_holds_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && ring_full) |=> $stable(write_slot) && $stable(fill))
    else $error("byte stored while the ring is full");

  a_pop_clears_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_byte && status.last_byte) |=> !ring_full)
    else $error("full flag still set after a message left the ring");

endmodule

// ----- design/crlf_line_framer_ring.sv -----
// CRLF line framer with a ring of message slots. A byte transfer (operation 0)
// stores the byte into the slot being filled, unless the ring is full or the
// line is being skipped after an overflow; a slot closes after CR LF or on
// overflow. A pop (operation 1) first registers the slot length and first byte,
// then gives one result per cycle while the result side takes them; the single
// read port of the byte store sets that pace. A pop of an empty ring gives one
// result of kind none. No new item is taken while a pop is streaming.
// Top level: instantiates clfr_ctrl and clfr_dp; depends on clfr_pkg.
module crlf_line_framer_ring #(
  parameter int MESSAGE_LENGTH = clfr_pkg::MESSAGE_LENGTH_DEF,
  parameter int MESSAGE_SLOTS  = clfr_pkg::MESSAGE_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  clfr_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output clfr_pkg::rsp_t rsp_data
);
  import clfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  clfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_op    (req_data.operation),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .status    (status)
  );

  clfr_dp #(
    .MESSAGE_LENGTH (MESSAGE_LENGTH),
    .MESSAGE_SLOTS  (MESSAGE_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (req_data.rx_byte),
    .cmd      (cmd),
    .status   (status),
    .rsp_data (rsp_data)
  );

endmodule

// ----- sim/crlf_line_framer_ring_tb.sv -----
// Testbench for crlf_line_framer_ring: drives byte and pop transfers, predicts every
// popped result with its own model of the message ring, and checks each result in order.
// Depends on clfr_pkg and the crlf_line_framer_ring RTL.
module crlf_line_framer_ring_tb;
  import clfr_pkg::*;

  localparam int MSG_LEN     = MESSAGE_LENGTH_DEF;
  localparam int MSG_SLOTS   = MESSAGE_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 2 * MSG_LEN + 8;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  logic [7:0]  frame_bytes [MSG_SLOTS * MSG_LEN];
  logic [6:0]  frame_len [MSG_SLOTS];
  int unsigned oldest_slot = 0;
  int unsigned fill_slot   = 0;
  bit          ring_is_full = 1'b0;
  bit          skipping     = 1'b0;
  bit          prev_was_cr  = 1'b0;
  rsp_t        due_rsp [$];

  crlf_line_framer_ring #(
    .MESSAGE_LENGTH(MSG_LEN),
    .MESSAGE_SLOTS (MSG_SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("crlf_line_framer_ring_tb: FAIL");
      $finish;
    end
  end

  task automatic advance_framer(input req_t item);
    rsp_t        r;
    int unsigned n;
    int unsigned pos;
    int unsigned i;
    bit          crlf;
    if (item.operation == OP_POP) begin
      if (!ring_is_full && fill_slot == oldest_slot) begin
        r.kind = KIND_NONE;
        r.data_byte = '0;
        r.byte_index = '0;
        r.message_length = '0;
        r.last = 1'b1;
        due_rsp.push_back(r);
      end else begin
        n = frame_len[oldest_slot];
        if (n > MSG_LEN) n = MSG_LEN;
        if (n == 0) begin
          r.kind = KIND_BYTE;
          r.data_byte = '0;
          r.byte_index = '0;
          r.message_length = '0;
          r.last = 1'b1;
          due_rsp.push_back(r);
        end
        for (i = 0; i < n; i++) begin
          r.kind = KIND_BYTE;
          r.data_byte = frame_bytes[oldest_slot * MSG_LEN + i];
          r.byte_index = 6'(i);
          r.message_length = 7'(n);
          r.last = (i + 1 == n);
          due_rsp.push_back(r);
        end
        frame_len[oldest_slot] = '0;
        oldest_slot = (oldest_slot + 1) % MSG_SLOTS;
        ring_is_full = 1'b0;
      end
    end else begin
      crlf = prev_was_cr && (item.rx_byte == CH_LF);
      if (!ring_is_full && !skipping) begin
        pos = frame_len[fill_slot];
        if (pos < MSG_LEN) begin
          frame_bytes[fill_slot * MSG_LEN + pos] = item.rx_byte;
          frame_len[fill_slot] = 7'(pos + 1);
        end else begin
          skipping = 1'b1;
        end
        if (pos >= MSG_LEN || crlf) begin
          fill_slot = (fill_slot + 1) % MSG_SLOTS;
          if (fill_slot == oldest_slot) ring_is_full = 1'b1;
          else frame_len[fill_slot] = '0;
        end
      end
      if (skipping && crlf) skipping = 1'b0;
      prev_was_cr = (item.rx_byte == CH_CR);
    end
  endtask

  task automatic send_item(input req_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    do @(posedge clk); while (!req_ready);
    advance_framer(item);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    req_t item;
    item.operation = OP_BYTE;
    item.rx_byte = b;
    send_item(item);
  endtask

  task automatic send_pop();
    req_t item;
    item.operation = OP_POP;
    item.rx_byte = 8'($urandom);
    send_item(item);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_CR);
    return b;
  endfunction

  task automatic send_line(input int unsigned body_len);
    int unsigned i;
    for (i = 0; i < body_len; i++) send_byte(text_byte());
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic test_directed_cases();
    send_pop();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_pop();
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(8'h41);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_pop();
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_pop();
    send_pop();
  endtask

  task automatic test_long_lines();
    int unsigned i;
    send_line(MSG_LEN - 2);
    send_pop();
    for (i = 0; i < MSG_LEN - 1; i++) send_byte(text_byte());
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_line(0);
    send_pop();
    send_pop();
    for (i = 0; i < MSG_LEN + 1; i++) send_byte(text_byte());
    repeat ($urandom_range(1, 3)) send_byte(text_byte());
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_line($urandom_range(0, 3));
    send_pop();
    send_pop();
    send_pop();
  endtask

  task automatic test_ring_full();
    while (ring_is_full || fill_slot != oldest_slot) send_pop();
    repeat (MSG_SLOTS) send_line($urandom_range(0, 3));
    send_byte(text_byte());
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_pop();
    send_byte(CH_LF);
    send_line($urandom_range(0, 2));
    while (ring_is_full || fill_slot != oldest_slot) send_pop();
    send_pop();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_line($urandom_range(0, 6));
      end else if (pick < 75) begin
        send_pop();
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0: send_byte(CH_CR);
          1: send_byte(CH_LF);
          default: send_byte(8'($urandom));
        endcase
      end else if (pick < 95) begin
        if ($urandom_range(1)) begin
          send_byte(CH_CR);
          send_byte(text_byte());
        end else begin
          send_byte(CH_LF);
        end
      end else begin
        send_line($urandom_range(20, 40));
      end
    end
  endtask

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d data=%02h idx=%0d len=%0d last=%0d",
                   rsp_data.kind, rsp_data.data_byte, rsp_data.byte_index,
                   rsp_data.message_length, rsp_data.last);
      end else begin
        exp_rsp = due_rsp.pop_front();
        if (rsp_data.kind != exp_rsp.kind || rsp_data.data_byte != exp_rsp.data_byte ||
            rsp_data.byte_index != exp_rsp.byte_index ||
            rsp_data.message_length != exp_rsp.message_length ||
            rsp_data.last != exp_rsp.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected kind=%0d data=%02h idx=%0d len=%0d last=%0d,",
                      " got kind=%0d data=%02h idx=%0d len=%0d last=%0d"},
                     exp_rsp.kind, exp_rsp.data_byte, exp_rsp.byte_index,
                     exp_rsp.message_length, exp_rsp.last,
                     rsp_data.kind, rsp_data.data_byte, rsp_data.byte_index,
                     rsp_data.message_length, rsp_data.last);
        end
      end
    end
  end

  initial begin
    foreach (frame_len[k]) frame_len[k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 33;
    recv_stall_pct = 63;
    test_directed_cases();
    test_long_lines();

    send_idle_pct  = 63;
    recv_stall_pct = 33;
    test_ring_full();
    test_random_traffic(30);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(50);

    req_valid <= 1'b0;
    while (due_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && due_rsp.size() == 0) begin
      $display("crlf_line_framer_ring_tb: PASS");
    end else begin
      $display("crlf_line_framer_ring_tb: FAIL");
    end
    $finish;
  end

endmodule
